// ----- rtl/fpth_pkg.sv -----
// ----------------------------------------------------------------------------
// fpth_pkg
// Shared constants, types and helper functions for the float pair hash.
// ----------------------------------------------------------------------------
package fpth_pkg;

  localparam logic [63:0] HASH_PRIME1 = 64'd11400714785074694791;
  localparam logic [63:0] HASH_PRIME2 = 64'd14029467366897019727;
  localparam logic [63:0] HASH_PRIME5 = 64'd2870177450012600261;
  localparam logic [63:0] HASH_LEN_SALT = 64'd3527539;
  localparam logic [63:0] HASH_ALLONES_SUB = 64'd1546275796;
  // length term added after both lanes are mixed in
  localparam logic [63:0] HASH_FINAL_ADD = 64'd2 ^ (HASH_PRIME5 ^ HASH_LEN_SALT);
  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  localparam int MERS_BITS = 61;
  localparam int SIG_BITS = 53;
  localparam int MIX_ROT = 31;
  localparam int MIX_ROT_BACK = 33;

  // u = exponent - 1075 + 19*61, always non-negative; u = biased exp + U_BIAS
  localparam logic [11:0] U_BIAS = 12'd84;
  // floor(2^16 / 61), an underestimate of the reciprocal
  localparam logic [21:0] RECIP61 = 22'd1074;
  localparam int RECIP_SHIFT = 16;
  localparam logic [11:0] MOD61 = 12'(MERS_BITS);

  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;

  typedef struct packed {
    logic valid;
    logic nf;
  } tag_t;

  function automatic logic [63:0] rotl31(input logic [63:0] x);
    rotl31 = (x << MIX_ROT) | (x >> MIX_ROT_BACK);
  endfunction

  // leading zero count of a nonzero 52-bit fraction (0 for zero input)
  function automatic logic [5:0] clz52(input logic [51:0] f);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 52; i++) begin
      if (f[i]) begin
        n = 6'(51 - i);
      end
    end
    clz52 = n;
  endfunction

endpackage

// ----- rtl/fpth_coord.sv -----
// ----------------------------------------------------------------------------
// fpth_coord
// Five-stage numeric hash of one binary64 coordinate modulo 2^61-1.
// ----------------------------------------------------------------------------
module fpth_coord (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [63:0] bits,
  output logic        out_valid,
  output logic        nf,
  output logic [63:0] hash
);

  localparam int SB = fpth_pkg::SIG_BITS;
  localparam int MB = fpth_pkg::MERS_BITS;

  // stage 1: decode and leading zero count
  logic        v1, nf1, neg1;
  logic [10:0] bexp1;
  logic [51:0] frac1;
  logic [5:0]  clz1;

  // stage 2: normalized significand and exponent reduction estimate
  logic          v2, nf2, neg2;
  logic [SB-1:0] sig2;
  logic [11:0]   u2;
  logic [5:0]    q2;
  logic [SB-1:0] sig2_next;
  logic [11:0]   u2_next;
  logic [21:0]   prod2;

  // stage 3: rotate amount
  logic          v3, nf3, neg3;
  logic [SB-1:0] sig3;
  logic [5:0]    sh3;
  logic [11:0]   diff3;
  logic [6:0]    r3;
  logic [5:0]    sh3_next;

  // stage 4: rotation inside the 61-bit field
  logic          v4, nf4, neg4;
  logic [MB-1:0] rot4;
  logic [MB-1:0] sig61;
  logic [2*MB-1:0] dbl4;

  // stage 5: sign and all-ones fixup
  logic        v5, nf5;
  logic [63:0] h5;
  logic [63:0] h5_raw;
  logic [63:0] h5_next;

  always_comb begin
    if (bexp1 != 11'd0) begin
      sig2_next = {1'b1, frac1};
      u2_next   = 12'(bexp1) + fpth_pkg::U_BIAS;
    end else begin
      sig2_next = {frac1, 1'b0} << clz1;
      u2_next   = fpth_pkg::U_BIAS - 12'(clz1);
    end
    prod2 = 22'(u2_next) * fpth_pkg::RECIP61;
  end

  always_comb begin
    diff3 = u2 - 12'(q2) * fpth_pkg::MOD61;
    r3    = diff3[6:0];
    // estimate may be one short: correct once
    if (r3 >= 7'(MB)) begin
      sh3_next = 6'(r3 - 7'(MB));
    end else begin
      sh3_next = r3[5:0];
    end
  end

  always_comb begin
    sig61 = MB'(sig3);
    dbl4  = {sig61, sig61} << sh3;
  end

  always_comb begin
    if (neg4) begin
      h5_raw = 64'd0 - 64'(rot4);
    end else begin
      h5_raw = 64'(rot4);
    end
    if (h5_raw == fpth_pkg::ALL_ONES) begin
      h5_next = fpth_pkg::ALL_ONES - 64'd1;
    end else begin
      h5_next = h5_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    nf1   <= (bits[62:52] == fpth_pkg::EXP_ALL_ONES);
    neg1  <= bits[63];
    bexp1 <= bits[62:52];
    frac1 <= bits[51:0];
    clz1  <= fpth_pkg::clz52(bits[51:0]);

    nf2  <= nf1;
    neg2 <= neg1;
    sig2 <= sig2_next;
    u2   <= u2_next;
    q2   <= prod2[fpth_pkg::RECIP_SHIFT +: 6];

    nf3  <= nf2;
    neg3 <= neg2;
    sig3 <= sig2;
    sh3  <= sh3_next;

    nf4  <= nf3;
    neg4 <= neg3;
    rot4 <= dbl4[2*MB-1:MB];

    nf5 <= nf4;
    h5  <= h5_next;
  end

  assign out_valid = v5;
  assign nf        = nf5;
  assign hash      = h5;

endmodule

// ----- rtl/fpth_mul64.sv -----
// ----------------------------------------------------------------------------
// fpth_mul64
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
// ----------------------------------------------------------------------------
module fpth_mul64 (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll;
  logic [63:0] hl_full, lh_full;
  logic [31:0] hl, lh;

  always_comb begin
    hl_full = 64'(a[63:32]) * 64'(b[31:0]);
    lh_full = 64'(a[31:0]) * 64'(b[63:32]);
  end

  always_ff @(posedge clk) begin
    ll <= 64'(a[31:0]) * 64'(b[31:0]);
    hl <= hl_full[31:0];
    lh <= lh_full[31:0];
    // cross terms only reach the upper word
    p  <= ll + {hl + lh, 32'd0};
  end

endmodule

// ----- rtl/fpth_mix.sv -----
// ----------------------------------------------------------------------------
// fpth_mix
// Pipelined two-element tuple mix of the coordinate hashes and final fixup.
// ----------------------------------------------------------------------------
module fpth_mix (
  input  logic               clk,
  input  logic               rst,
  input  fpth_pkg::tag_t     in_tag,
  input  logic [63:0]        hx,
  input  logic [63:0]        hy,
  output fpth_pkg::tag_t     out_tag,
  output logic [63:0]        hash
);

  localparam int TAG_DEPTH = 8;

  fpth_pkg::tag_t tag_pipe [TAG_DEPTH];

  logic [63:0] px, py;
  logic [63:0] py_d1, py_d2, py_d3;
  logic [63:0] a_acc, b_acc, c_acc, d_acc;
  logic [63:0] sum_fin;
  logic [63:0] hash_next;

  fpth_mul64 u_mul_x (.clk(clk), .a(hx), .b(fpth_pkg::HASH_PRIME2), .p(px));
  fpth_mul64 u_mul_y (.clk(clk), .a(hy), .b(fpth_pkg::HASH_PRIME2), .p(py));
  fpth_mul64 u_mul_a (.clk(clk), .a(a_acc), .b(fpth_pkg::HASH_PRIME1), .p(b_acc));
  fpth_mul64 u_mul_c (.clk(clk), .a(c_acc), .b(fpth_pkg::HASH_PRIME1), .p(d_acc));

  always_comb begin
    sum_fin = d_acc + fpth_pkg::HASH_FINAL_ADD;
    if (tag_pipe[TAG_DEPTH-1].nf) begin
      hash_next = 64'd0;
    end else if (sum_fin == fpth_pkg::ALL_ONES) begin
      hash_next = fpth_pkg::HASH_ALLONES_SUB;
    end else begin
      hash_next = sum_fin;
    end
  end

  always_ff @(posedge clk) begin
    a_acc <= fpth_pkg::rotl31(fpth_pkg::HASH_PRIME5 + px);
    // hold the second lane product until the first lane is done
    py_d1 <= py;
    py_d2 <= py_d1;
    py_d3 <= py_d2;
    c_acc <= fpth_pkg::rotl31(b_acc + py_d3);
    hash  <= hash_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAG_DEPTH; i++) begin
        tag_pipe[i] <= '0;
      end
      out_tag <= '0;
    end else begin
      tag_pipe[0] <= in_tag;
      for (int i = 1; i < TAG_DEPTH; i++) begin
        tag_pipe[i] <= tag_pipe[i-1];
      end
      out_tag <= tag_pipe[TAG_DEPTH-1];
    end
  end

endmodule

// ----- rtl/float_pair_tuple_hash.sv -----
// ----------------------------------------------------------------------------
// float_pair_tuple_hash
// Hash of a point given as two raw binary64 bit patterns.
// ----------------------------------------------------------------------------
// Usage:
//   A word (x_bits, y_bits) is taken at a rising edge with start high and
//   busy low. busy stays low: the pipeline takes a new word every cycle.
//   Each word gives one result on hash_value / not_finite, shown for one
//   cycle with done high. done comes from the last register of the mix
//   tag pipeline, which runs in step with the hash.
//   Throughput is one word per cycle. A word passes through five coordinate
//   stages (decode and leading zero count, normalize, exponent mod 61,
//   rotate, sign fixup) and nine mix stages built around three chained
//   64-bit multiplies, each cut into 32x32 partial products over two
//   stages.
//   not_finite is high when either coordinate is infinity or NaN; the
//   hash is then 0.
//   Synchronous reset clears all valid bits; words in flight are dropped.
//   The receiver cannot stall, so no back pressure exists.
// ----------------------------------------------------------------------------
module float_pair_tuple_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] x_bits,
  input  logic [63:0] y_bits,
  output logic        done,
  output logic [63:0] hash_value,
  output logic        not_finite
);

  logic           accept;
  logic           x_valid, y_valid;
  logic           x_nf, y_nf;
  logic [63:0]    hx, hy;
  fpth_pkg::tag_t mix_in_tag;
  fpth_pkg::tag_t mix_out_tag;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  fpth_coord u_coord_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .bits      (x_bits),
    .out_valid (x_valid),
    .nf        (x_nf),
    .hash      (hx)
  );

  fpth_coord u_coord_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .bits      (y_bits),
    .out_valid (y_valid),
    .nf        (y_nf),
    .hash      (hy)
  );

  always_comb begin
    mix_in_tag.valid = x_valid & y_valid;
    mix_in_tag.nf    = x_nf | y_nf;
  end

  fpth_mix u_mix (
    .clk     (clk),
    .rst     (rst),
    .in_tag  (mix_in_tag),
    .hx      (hx),
    .hy      (hy),
    .out_tag (mix_out_tag),
    .hash    (hash_value)
  );

  assign done       = mix_out_tag.valid;
  assign not_finite = mix_out_tag.nf;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    x_valid == y_valid)
    else $error("coordinate lanes out of step");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    done && not_finite |-> hash_value == 64'd0)
    else $error("non-finite word with nonzero hash");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##14 done)
    else $error("accepted word produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 14))
    else $error("result without accepted word");

endmodule
